// ===== hw/rtl/ect_pkg.sv =====
// ----------------------------------------------------------------------------
// Ear clipping triangulator package
// Shared widths, state and mode codes, and the multiply-accumulate controls.
// ----------------------------------------------------------------------------
`default_nettype none

package ect_pkg;

  localparam int CoordW   = 16;
  localparam int Capacity = 64;
  localparam int IdxW     = 6;
  localparam int CntW     = 7;
  localparam int StepW    = 5;
  localparam int DiffW    = CoordW + 1;
  localparam int CrossW   = 2 * DiffW + 2;
  localparam int NormW    = 40;
  localparam int ChunkW   = 21;
  localparam int BFullW   = 2 * ChunkW;
  localparam int MacAW    = CrossW;
  localparam int MacBW    = ChunkW + 1;
  localparam int AccW     = 80;

  typedef logic [2:0][CoordW-1:0] vtx_t;

  typedef enum logic [3:0] {
    StIdle,
    StNwStart,
    StNwPrime,
    StNwMac,
    StNwStore,
    StLink,
    StTop,
    StLinkRd,
    StFetch,
    StCalc,
    StTFetch,
    StTNext,
    StTNext2,
    StFail,
    StEmit,
    StShort
  } state_e;

  typedef enum logic [1:0] {
    ModeFlip,
    ModeSide1,
    ModeSide2,
    ModeSide3
  } mode_e;

  typedef struct packed {
    logic en;
    logic clr;
    logic neg;
    logic hi;
  } mac_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ect_mac.sv =====
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Signed operand times one signed chunk, optionally shifted up by one chunk,
// added to or subtracted from a wide accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module ect_mac (
  input  logic                                clk_i,
  input  ect_pkg::mac_ctl_t                   ctl_i,
  input  logic signed [ect_pkg::MacAW-1:0]    a_i,
  input  logic signed [ect_pkg::MacBW-1:0]    b_i,
  output logic signed [ect_pkg::AccW-1:0]     acc_o,
  output logic signed [ect_pkg::AccW-1:0]     acc_d_o
);
  import ect_pkg::*;

  localparam int ProdW = MacAW + MacBW;

  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  term;
  logic signed [AccW-1:0]  base;
  logic signed [AccW-1:0]  acc_q;

  assign prod = a_i * b_i;

  always_comb begin
    term = AccW'(prod);
    if (ctl_i.hi) begin
      term = term <<< ChunkW;
    end
    base = ctl_i.clr ? '0 : acc_q;
    acc_d_o = ctl_i.neg ? (base - term) : (base + term);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      acc_q <= acc_d_o;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ear_clipping_triangulator.sv =====
// ----------------------------------------------------------------------------
// Ear clipping triangulator
// Loads a 3D polygon and emits its triangulation as vertex index triples.
// ----------------------------------------------------------------------------
// Vertices load one per cycle while the block is idle; up to 64 are kept and
// later ones are dropped and flagged. The vertex marked final starts the
// triangulation, and input stays stalled until the last triangle has been
// placed in the output register. All geometry runs through one shared
// multiply-accumulate unit. The block first computes the plane normal and
// builds the link ring; each ear candidate then takes link reads, vertex
// fetches and an orientation test, and every point tested against it a
// fetch, up to three side tests and a link walk. The total time grows
// roughly with the square of the vertex count and is set by that unit and
// the single read port of the vertex memory. The configuration register is
// written only while idle.
`default_nettype none

module ear_clipping_triangulator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [15:0]          coord_x_i,
  input  logic signed [15:0]          coord_y_i,
  input  logic signed [15:0]          coord_z_i,
  input  logic                        final_vertex_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ect_pkg::IdxW-1:0]    corner_a_o,
  output logic [ect_pkg::IdxW-1:0]    corner_b_o,
  output logic [ect_pkg::IdxW-1:0]    corner_c_o,
  output logic                        last_triangle_o,
  output logic                        empty_polygon_o,
  output logic                        overflow_flag_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_data_i
);
  import ect_pkg::*;

  localparam int CrossLen = 6;
  localparam int CalcEnd  = 3 * CrossLen;

  function automatic logic signed [DiffW-1:0] cdiff(logic [CoordW-1:0] a,
                                                    logic [CoordW-1:0] b);
    return DiffW'($signed(a)) - DiffW'($signed(b));
  endfunction

  function automatic logic signed [DiffW-1:0] csum(logic [CoordW-1:0] a,
                                                   logic [CoordW-1:0] b);
    return DiffW'($signed(a)) + DiffW'($signed(b));
  endfunction

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [1:0]       comp_q, comp_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             dropped_q, dropped_d;
  logic [CntW-1:0]  n_q, n_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  failed_q, failed_d;
  logic [IdxW-1:0]  e_q, e_d, p_q, p_d, q_q, q_d, t_q, t_d;
  vtx_t             vp_q, vp_d, ve_q, ve_d, vq_q, vq_d, vt_q, vt_d;
  logic [2:0][CrossW-1:0] x_q, x_d, y_q, y_d;
  logic [2:0][NormW-1:0]  norm_q, norm_d;
  logic             hole_q;

  logic             out_valid_q, out_valid_d;
  logic [IdxW-1:0]  oa_q, oa_d, ob_q, ob_d, oc_q, oc_d;
  logic             olast_q, olast_d, oempty_q, oempty_d, oovf_q, oovf_d;

  vtx_t             vmem [Capacity];
  vtx_t             vrd_q;
  logic [IdxW-1:0]  prev_mem [Capacity];
  logic [IdxW-1:0]  next_mem [Capacity];
  logic [IdxW-1:0]  prev_rd_q, next_rd_q;

  logic             in_acc, out_free, has_room;
  logic [CntW-1:0]  n_new;
  logic             v_we;
  logic [IdxW-1:0]  vaddr, lk_raddr;
  logic             pw_en, nw_en;
  logic [IdxW-1:0]  pw_addr, pw_data, nw_addr, nw_data;

  mac_ctl_t                  mac_ctl;
  logic signed [MacAW-1:0]   mac_a;
  logic signed [MacBW-1:0]   mac_b;
  logic signed [AccW-1:0]    acc, acc_d;

  logic             cross_a, cross_b, in_calc;
  logic [2:0]       sub;
  logic [1:0]       k;
  logic             s;
  logic             flipped;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign has_room    = (count_q < CntW'(Capacity));
  assign n_new       = count_q + CntW'(has_room);
  assign v_we        = in_acc && has_room;
  assign cfg_ready_o = (state_q == StIdle);
  assign flipped     = acc[AccW-1] || (acc == '0);

  // Step decode inside the geometry phase
  always_comb begin
    in_calc = (state_q == StCalc) && (cnt_q < StepW'(CalcEnd));
    cross_a = (cnt_q < StepW'(CrossLen));
    cross_b = !cross_a && (cnt_q < StepW'(2 * CrossLen)) && (mode_q != ModeFlip);
    if (cross_a) begin
      sub = cnt_q[2:0];
    end else if (cross_b) begin
      sub = 3'(cnt_q - StepW'(CrossLen));
    end else begin
      sub = 3'(cnt_q - StepW'(2 * CrossLen));
    end
    k = sub[2:1];
    s = sub[0];
  end

  ect_mac u_mac (
    .clk_i   (clk_i),
    .ctl_i   (mac_ctl),
    .a_i     (mac_a),
    .b_i     (mac_b),
    .acc_o   (acc),
    .acc_d_o (acc_d)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc && final_vertex_i) begin
          if (n_new < CntW'(3)) begin
            state_d = StShort;
          end else if (n_new == CntW'(3)) begin
            state_d = StEmit;
          end else begin
            state_d = StNwStart;
          end
        end
      end
      StNwStart: state_d = StNwPrime;
      StNwPrime: state_d = StNwMac;
      StNwMac: begin
        if (idx_q == CntW'(n_q - 1'b1)) state_d = StNwStore;
      end
      StNwStore: state_d = (comp_q == 2'd2) ? StLink : StNwStart;
      StLink: begin
        if (idx_q == CntW'(n_q - 1'b1)) state_d = StTop;
      end
      StTop: state_d = StLinkRd;
      StLinkRd: begin
        state_d = ((rem_q > CntW'(3)) && (failed_q < rem_q)) ? StFetch : StEmit;
      end
      StFetch: begin
        if (cnt_q == StepW'(3)) state_d = StCalc;
      end
      StCalc: begin
        if (cnt_q == StepW'(CalcEnd)) begin
          if (mode_q == ModeFlip) begin
            state_d = flipped ? StFail : StTFetch;
          end else if (acc[AccW-1]) begin
            state_d = StTNext;
          end else if (mode_q == ModeSide3) begin
            state_d = StFail;
          end
        end
      end
      StTFetch: begin
        if (cnt_q == StepW'(1)) state_d = StCalc;
      end
      StTNext:  state_d = StTNext2;
      StTNext2: state_d = (next_rd_q == p_q) ? StEmit : StTFetch;
      StFail:   state_d = StTop;
      StEmit: begin
        if (out_free) state_d = (rem_q == CntW'(3)) ? StIdle : StTop;
      end
      StShort: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Memory addressing, link writes and the shared unit's operands
  always_comb begin
    vtx_t o_v, v1_v, wa_v, wb_v, w_v, cur, prv;
    logic [1:0] k1, k2;
    logic signed [DiffW-1:0] da, db;
    logic signed [BFullW-1:0] bfull;

    vaddr    = '0;
    lk_raddr = e_q;
    pw_en    = 1'b0;
    nw_en    = 1'b0;
    pw_addr  = p_q;
    pw_data  = '0;
    nw_addr  = p_q;
    nw_data  = '0;
    mac_ctl  = '0;
    mac_a    = '0;
    mac_b    = '0;
    cur      = vrd_q;
    prv      = vt_q;

    unique case (mode_q)
      ModeSide1: begin o_v = vp_q; v1_v = ve_q; wa_v = vt_q; wb_v = vq_q; end
      ModeSide2: begin o_v = ve_q; v1_v = vq_q; wa_v = vt_q; wb_v = vp_q; end
      ModeSide3: begin o_v = vq_q; v1_v = vp_q; wa_v = vt_q; wb_v = ve_q; end
      default:   begin o_v = vp_q; v1_v = ve_q; wa_v = vq_q; wb_v = vq_q; end
    endcase
    w_v = cross_b ? wb_v : wa_v;

    case (k)
      2'd0:    begin k1 = 2'd1; k2 = 2'd2; end
      2'd1:    begin k1 = 2'd2; k2 = 2'd0; end
      default: begin k1 = 2'd0; k2 = 2'd1; end
    endcase

    if (s) begin
      da = cdiff(v1_v[k2], o_v[k2]);
      db = cdiff(w_v[k1], o_v[k1]);
    end else begin
      da = cdiff(v1_v[k1], o_v[k1]);
      db = cdiff(w_v[k2], o_v[k2]);
    end
    bfull = (mode_q == ModeFlip) ? BFullW'($signed(norm_q[k]))
                                 : BFullW'($signed(y_q[k]));

    unique case (state_q)
      StNwStart: vaddr = IdxW'(n_q - 1'b1);
      StNwPrime: vaddr = '0;
      StNwMac: begin
        vaddr       = IdxW'(idx_q + 1'b1);
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = (idx_q == '0);
        case (comp_q)
          2'd0: begin
            mac_a = MacAW'(cdiff(cur[1], prv[1]));
            mac_b = MacBW'(csum(prv[2], cur[2]));
          end
          2'd1: begin
            mac_a = MacAW'(cdiff(cur[2], prv[2]));
            mac_b = MacBW'(csum(prv[0], cur[0]));
          end
          default: begin
            mac_a = MacAW'(cdiff(cur[0], prv[0]));
            mac_b = MacBW'(csum(prv[1], cur[1]));
          end
        endcase
      end
      StLink: begin
        pw_en   = 1'b1;
        nw_en   = 1'b1;
        pw_addr = idx_q[IdxW-1:0];
        nw_addr = idx_q[IdxW-1:0];
        pw_data = (idx_q == '0) ? IdxW'(n_q - 1'b1) : IdxW'(idx_q - 1'b1);
        nw_data = (idx_q == CntW'(n_q - 1'b1)) ? '0 : IdxW'(idx_q + 1'b1);
      end
      StTop: lk_raddr = e_q;
      StFetch: begin
        case (cnt_q)
          StepW'(0): begin vaddr = p_q; lk_raddr = q_q; end
          StepW'(1): vaddr = e_q;
          default:   vaddr = q_q;
        endcase
      end
      StCalc: begin
        if (in_calc) begin
          mac_ctl.en = 1'b1;
          if (cross_a || cross_b) begin
            mac_ctl.clr = !s;
            mac_ctl.neg = s;
            mac_a       = MacAW'(da);
            mac_b       = MacBW'(db);
          end else begin
            mac_ctl.clr = (sub == 3'd0);
            mac_ctl.hi  = s;
            mac_a       = $signed(x_q[k]);
            mac_b       = s ? MacBW'($signed(bfull[BFullW-1:ChunkW]))
                            : {1'b0, bfull[ChunkW-1:0]};
          end
        end
      end
      StTFetch: vaddr = t_q;
      StTNext:  lk_raddr = t_q;
      StEmit: begin
        if (out_free) begin
          // unlink the clipped vertex
          nw_en   = 1'b1;
          nw_addr = p_q;
          nw_data = q_q;
          pw_en   = 1'b1;
          pw_addr = q_q;
          pw_data = p_q;
        end
      end
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    mode_d      = mode_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    comp_d      = comp_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    n_d         = n_q;
    rem_d       = rem_q;
    failed_d    = failed_q;
    e_d         = e_q;
    p_d         = p_q;
    q_d         = q_q;
    t_d         = t_q;
    vp_d        = vp_q;
    ve_d        = ve_q;
    vq_d        = vq_q;
    vt_d        = vt_q;
    x_d         = x_q;
    y_d         = y_q;
    norm_d      = norm_q;
    out_valid_d = out_valid_q && out_stall_i;
    oa_d        = oa_q;
    ob_d        = ob_q;
    oc_d        = oc_q;
    olast_d     = olast_q;
    oempty_d    = oempty_q;
    oovf_d      = oovf_q;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (has_room) begin
            count_d = count_q + 1'b1;
          end else begin
            dropped_d = 1'b1;
          end
          if (final_vertex_i) begin
            n_d    = n_new;
            rem_d  = n_new;
            comp_d = '0;
            p_d    = IdxW'(0);
            e_d    = IdxW'(1);
            q_d    = IdxW'(2);
          end
        end
      end
      StNwPrime: begin
        vt_d  = vrd_q;
        idx_d = '0;
      end
      StNwMac: begin
        vt_d  = vrd_q;
        idx_d = idx_q + 1'b1;
      end
      StNwStore: begin
        norm_d[comp_q] = acc[NormW-1:0];
        idx_d          = '0;
        comp_d         = comp_q + 1'b1;
      end
      StLink: begin
        idx_d    = idx_q + 1'b1;
        e_d      = '0;
        failed_d = '0;
        rem_d    = n_q;
      end
      StLinkRd: begin
        p_d   = prev_rd_q;
        q_d   = next_rd_q;
        cnt_d = '0;
      end
      StFetch: begin
        cnt_d = cnt_q + 1'b1;
        case (cnt_q)
          StepW'(1): begin vp_d = vrd_q; t_d = next_rd_q; end
          StepW'(2): ve_d = vrd_q;
          StepW'(3): begin
            vq_d   = vrd_q;
            cnt_d  = '0;
            mode_d = ModeFlip;
          end
          default: ;
        endcase
      end
      StCalc: begin
        cnt_d = cnt_q + 1'b1;
        if (in_calc && s) begin
          if (cross_a) x_d[k] = acc_d[CrossW-1:0];
          if (cross_b) y_d[k] = acc_d[CrossW-1:0];
        end
        // the orientation test has no second cross product
        if ((mode_q == ModeFlip) && (cnt_q == StepW'(CrossLen - 1))) begin
          cnt_d = StepW'(2 * CrossLen);
        end
        if (cnt_q == StepW'(CalcEnd)) begin
          cnt_d = '0;
          if ((mode_q != ModeFlip) && !acc[AccW-1] && (mode_q != ModeSide3)) begin
            mode_d = mode_e'(mode_q + 1'b1);
          end
        end
      end
      StTFetch: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == StepW'(1)) begin
          vt_d   = vrd_q;
          cnt_d  = '0;
          mode_d = ModeSide1;
        end
      end
      StTNext2: begin
        t_d   = next_rd_q;
        cnt_d = '0;
      end
      StFail: begin
        e_d      = q_q;
        failed_d = failed_q + 1'b1;
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          oa_d        = p_q;
          ob_d        = hole_q ? q_q : e_q;
          oc_d        = hole_q ? e_q : q_q;
          olast_d     = (rem_q == CntW'(3));
          oempty_d    = 1'b0;
          oovf_d      = dropped_q;
          rem_d       = rem_q - 1'b1;
          e_d         = p_q;
          failed_d    = '0;
          if (rem_q == CntW'(3)) begin
            count_d   = '0;
            dropped_d = 1'b0;
          end
        end
      end
      StShort: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          oa_d        = '0;
          ob_d        = '0;
          oc_d        = '0;
          olast_d     = 1'b1;
          oempty_d    = 1'b1;
          oovf_d      = dropped_q;
          count_d     = '0;
          dropped_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      hole_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        hole_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    cnt_q    <= cnt_d;
    idx_q    <= idx_d;
    comp_q   <= comp_d;
    n_q      <= n_d;
    rem_q    <= rem_d;
    failed_q <= failed_d;
    e_q      <= e_d;
    p_q      <= p_d;
    q_q      <= q_d;
    t_q      <= t_d;
    vp_q     <= vp_d;
    ve_q     <= ve_d;
    vq_q     <= vq_d;
    vt_q     <= vt_d;
    x_q      <= x_d;
    y_q      <= y_d;
    norm_q   <= norm_d;
    oa_q     <= oa_d;
    ob_q     <= ob_d;
    oc_q     <= oc_d;
    olast_q  <= olast_d;
    oempty_q <= oempty_d;
    oovf_q   <= oovf_d;
  end

  // Vertex memory
  always_ff @(posedge clk_i) begin
    if (v_we) begin
      vmem[count_q[IdxW-1:0]] <= {coord_z_i, coord_y_i, coord_x_i};
    end
    vrd_q <= vmem[vaddr];
  end

  // Ring link memories
  always_ff @(posedge clk_i) begin
    if (pw_en) begin
      prev_mem[pw_addr] <= pw_data;
    end
    prev_rd_q <= prev_mem[lk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (nw_en) begin
      next_mem[nw_addr] <= nw_data;
    end
    next_rd_q <= next_mem[lk_raddr];
  end

  assign out_valid_o     = out_valid_q;
  assign corner_a_o      = oa_q;
  assign corner_b_o      = ob_q;
  assign corner_c_o      = oc_q;
  assign last_triangle_o = olast_q;
  assign empty_polygon_o = oempty_q;
  assign overflow_flag_o = oovf_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ect_checker.sv =====
// ----------------------------------------------------------------------------
// Ear clipping triangulator checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ect_checker (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     out_valid_o,
  input wire logic                     out_stall_i,
  input wire logic [ect_pkg::IdxW-1:0] corner_a_o,
  input wire logic [ect_pkg::IdxW-1:0] corner_b_o,
  input wire logic [ect_pkg::IdxW-1:0] corner_c_o,
  input wire logic                     last_triangle_o,
  input wire logic                     empty_polygon_o,
  input wire logic                     overflow_flag_o
);

  // hold a stalled transaction
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(corner_a_o) &&
    $stable(corner_b_o) && $stable(corner_c_o) && $stable(last_triangle_o) &&
    $stable(empty_polygon_o) && $stable(overflow_flag_o))
    else $error("stalled result changed");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_polygon_o |-> last_triangle_o &&
    corner_a_o == '0 && corner_b_o == '0 && corner_c_o == '0)
    else $error("empty result malformed");

  a_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !empty_polygon_o |-> corner_a_o != corner_b_o &&
    corner_b_o != corner_c_o && corner_a_o != corner_c_o)
    else $error("triangle corners repeat");

  // overflow is per polygon: a non-final transaction carries it into the next
  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_triangle_o ##1 out_valid_o |->
    overflow_flag_o == $past(overflow_flag_o))
    else $error("overflow flag changed within a polygon");

endmodule

bind ear_clipping_triangulator ect_checker u_ect_checker (.*);

`default_nettype wire
